/* rtl/let_pkg.sv */
`timescale 1ns / 1ps

package let_pkg;

   typedef enum logic [1:0] {
      MODE_BLINK,
      MODE_RAMP_UP,
      MODE_RAMP_DOWN,
      MODE_CYCLE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_RELOAD,
      ST_MUL,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   localparam logic [15:0] INTERVAL_RESET = 16'd1000;
   localparam logic        CSR_IDX_INTERVAL = 1'b0;

   localparam logic [7:0]  PCT_MIN = 8'd10;
   localparam logic [7:0]  PCT_MAX = 8'd100;
   localparam logic [15:0] RATIO_DIVIDEND = 16'd100;

   // divider: 16-bit dividend, 9-bit divisor, one quotient bit per cycle
   localparam int          DIV_BITS = 16;
   localparam int          DVSR_BITS = 9;
   localparam logic [3:0]  DIV_LAST = 4'(DIV_BITS - 1);

endpackage

/* rtl/led_effect_timer_unit.sv */
`timescale 1ns / 1ps

// LED effect timer: each request transaction carries the millisecond time, the
// effect mode and the level parameters, and yields one response transaction with
// the next LED level. Period start time and step counter persist between
// transactions. All divisions run through one shared restoring divider, one
// quotient bit per cycle; the cycle mode adds one registered 16x16 multiply.
// Blink runs two divisions, ramp and cycle one each when they step, and a held
// level none; rsp_tvalid may also wait for a stalled earlier response. One
// request is in work at a time; req_tready returns at the edge that loads the
// response into its output register, which may still wait for rsp_tready.
module led_effect_timer_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: now_ms[31:0], current_level[39:32], from_level[47:40],
   //            to_level[55:48], intensity[63:56], on_percent[71:64]
   input  logic [71:0] req_tdata,
   // req_tuser: mode[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: level_out[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   let_pkg::state_type state_ff, state_in;
   let_pkg::mode_type  mode_ff, mode_in;

   logic [31:0] now_ff, now_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  from_ff, from_in;
   logic [7:0]  to_ff, to_in;
   logic [7:0]  inten_ff, inten_in;
   logic [7:0]  pct_ff, pct_in;

   logic [15:0] interval_ff, interval_in;
   logic [31:0] ps_ff, ps_in;
   logic [15:0] sc_ff, sc_in;

   logic [31:0] elapsed_ff, elapsed_in;
   logic [let_pkg::DVSR_BITS-1:0] rem_ff, rem_in;
   logic [let_pkg::DIV_BITS-1:0]  quot_ff, quot_in;
   logic [let_pkg::DVSR_BITS-1:0] divisor_ff, divisor_in;
   logic [3:0]  count_ff, count_in;
   logic        pass_ff, pass_in;
   logic [31:0] prod_ff, prod_in;
   logic [7:0]  level_ff, level_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic        req_acc;
   logic        csr_wr;
   logic [31:0] elapsed0;
   logic        over;
   logic        prep_div;
   logic [7:0]  pct_clamp;
   logic [let_pkg::DVSR_BITS:0] trial;
   logic        trial_ge;
   logic [let_pkg::DVSR_BITS:0] trial_diff;
   logic [let_pkg::DVSR_BITS-1:0] div_step_rem;
   logic [let_pkg::DIV_BITS-1:0]  div_step_quot;
   logic        out_free;

   assign req_tready = (state_ff == let_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == let_pkg::CSR_IDX_INTERVAL);
   assign csr_prdata = (csr_paddr[2] == let_pkg::CSR_IDX_INTERVAL) ?
                       {16'd0, interval_ff} : 32'd0;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign elapsed0 = now_ff - ps_ff;
   assign over     = elapsed0 > {16'd0, interval_ff};

   always_comb begin
      if (pct_ff < let_pkg::PCT_MIN) begin
         pct_clamp = let_pkg::PCT_MIN;
      end else if (pct_ff > let_pkg::PCT_MAX) begin
         pct_clamp = let_pkg::PCT_MAX;
      end else begin
         pct_clamp = pct_ff;
      end
   end

   always_comb begin
      case (mode_ff)
         let_pkg::MODE_BLINK:     prep_div = 1'b1;
         let_pkg::MODE_RAMP_UP:   prep_div = (to_ff > cur_ff) && (to_ff > from_ff);
         let_pkg::MODE_RAMP_DOWN: prep_div = (to_ff < cur_ff) && (from_ff > to_ff);
         let_pkg::MODE_CYCLE:     prep_div = (to_ff > from_ff);
         default:                 prep_div = 1'b0;
      endcase
   end

   // shared restoring divider step
   assign trial         = {rem_ff, quot_ff[let_pkg::DIV_BITS-1]};
   assign trial_ge      = trial >= {1'b0, divisor_ff};
   assign trial_diff    = trial - {1'b0, divisor_ff};
   assign div_step_rem  = trial_ge ? trial_diff[let_pkg::DVSR_BITS-1:0]
                                   : trial[let_pkg::DVSR_BITS-1:0];
   assign div_step_quot = {quot_ff[let_pkg::DIV_BITS-2:0], trial_ge};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         let_pkg::ST_IDLE: begin
            if (req_acc) state_in = let_pkg::ST_PREP;
         end
         let_pkg::ST_PREP: begin
            state_in = prep_div ? let_pkg::ST_DIV : let_pkg::ST_FINISH;
         end
         let_pkg::ST_DIV: begin
            if (count_ff == 4'd0) begin
               if (mode_ff == let_pkg::MODE_BLINK && !pass_ff) begin
                  state_in = let_pkg::ST_RELOAD;
               end else if (mode_ff == let_pkg::MODE_CYCLE) begin
                  state_in = let_pkg::ST_MUL;
               end else begin
                  state_in = let_pkg::ST_DECIDE;
               end
            end
         end
         let_pkg::ST_RELOAD: state_in = let_pkg::ST_DIV;
         let_pkg::ST_MUL:    state_in = let_pkg::ST_DECIDE;
         let_pkg::ST_DECIDE: state_in = let_pkg::ST_FINISH;
         let_pkg::ST_FINISH: begin
            if (out_free) state_in = let_pkg::ST_IDLE;
         end
         default: state_in = let_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      mode_in      = mode_ff;
      now_in       = now_ff;
      cur_in       = cur_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      inten_in     = inten_ff;
      pct_in       = pct_ff;
      interval_in  = interval_ff;
      ps_in        = ps_ff;
      sc_in        = sc_ff;
      elapsed_in   = elapsed_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      divisor_in   = divisor_ff;
      count_in     = count_ff;
      pass_in      = pass_ff;
      prod_in      = prod_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr) interval_in = csr_pwdata[15:0];
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         let_pkg::ST_IDLE: begin
            if (req_acc) begin
               mode_in  = let_pkg::mode_type'(req_tuser);
               now_in   = req_tdata[31:0];
               cur_in   = req_tdata[39:32];
               from_in  = req_tdata[47:40];
               to_in    = req_tdata[55:48];
               inten_in = req_tdata[63:56];
               pct_in   = req_tdata[71:64];
            end
         end
         let_pkg::ST_PREP: begin
            elapsed_in = elapsed0;
            rem_in     = '0;
            count_in   = let_pkg::DIV_LAST;
            pass_in    = 1'b0;
            quot_in    = interval_ff;
            level_in   = cur_ff;
            case (mode_ff)
               let_pkg::MODE_BLINK: begin
                  if (over) begin
                     ps_in      = now_ff;
                     elapsed_in = '0;
                  end
                  quot_in    = let_pkg::RATIO_DIVIDEND;
                  divisor_in = {1'b0, pct_clamp};
               end
               let_pkg::MODE_RAMP_UP: begin
                  divisor_in = {1'b0, 8'(to_ff - from_ff)};
               end
               let_pkg::MODE_RAMP_DOWN: begin
                  divisor_in = {1'b0, 8'(from_ff - to_ff)};
               end
               let_pkg::MODE_CYCLE: begin
                  if (over) begin
                     ps_in      = now_ff;
                     elapsed_in = '0;
                     sc_in      = 16'd1;
                  end else if (sc_ff == 16'd0) begin
                     sc_in = 16'd1;
                  end
                  divisor_in = {8'(to_ff - from_ff), 1'b0};
               end
               default: ;
            endcase
         end
         let_pkg::ST_DIV: begin
            rem_in   = div_step_rem;
            quot_in  = div_step_quot;
            count_in = count_ff - 4'd1;
         end
         let_pkg::ST_RELOAD: begin
            divisor_in = quot_ff[let_pkg::DVSR_BITS-1:0];
            quot_in    = interval_ff;
            rem_in     = '0;
            count_in   = let_pkg::DIV_LAST;
            pass_in    = 1'b1;
         end
         let_pkg::ST_MUL: begin
            prod_in = quot_ff * sc_ff;
         end
         let_pkg::ST_DECIDE: begin
            case (mode_ff)
               let_pkg::MODE_BLINK: begin
                  level_in = (elapsed_ff < {16'd0, quot_ff}) ? inten_ff : 8'd0;
               end
               let_pkg::MODE_RAMP_UP: begin
                  if (elapsed_ff > {16'd0, quot_ff}) begin
                     ps_in    = now_ff;
                     level_in = cur_ff + 8'd1;
                  end
               end
               let_pkg::MODE_RAMP_DOWN: begin
                  if (elapsed_ff > {16'd0, quot_ff}) begin
                     ps_in    = now_ff;
                     level_in = cur_ff - 8'd1;
                  end
               end
               let_pkg::MODE_CYCLE: begin
                  if (elapsed_ff > {17'd0, interval_ff[15:1]}) begin
                     if (from_ff < cur_ff && elapsed_ff > prod_ff) begin
                        sc_in    = sc_ff + 16'd1;
                        level_in = cur_ff - 8'd1;
                     end
                  end else if (to_ff > cur_ff && elapsed_ff > prod_ff) begin
                     sc_in    = sc_ff + 16'd1;
                     level_in = cur_ff + 8'd1;
                  end
               end
               default: ;
            endcase
         end
         let_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = level_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= let_pkg::ST_IDLE;
         interval_ff  <= let_pkg::INTERVAL_RESET;
         ps_ff        <= '0;
         sc_ff        <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         ps_ff        <= ps_in;
         sc_ff        <= sc_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      cur_ff      <= cur_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      inten_ff    <= inten_in;
      pct_ff      <= pct_in;
      elapsed_ff  <= elapsed_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      divisor_ff  <= divisor_in;
      count_ff    <= count_in;
      prod_ff     <= prod_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/let_checker.sv */
`timescale 1ns / 1ps

module let_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // one transaction in work at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after a request transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the channels");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]
      |=> csr_paddr[2] ||
          (csr_prdata == {16'd0, $past(csr_pwdata[15:0])}))
      else $error("interval register readback mismatch");

endmodule

bind led_effect_timer_unit let_checker u_let_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
